/* design/ifhg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_pkg
// Shared types and constants of the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
package ifhg_pkg;

    localparam int MAX_FRAGMENTS_DEF = 64;

    localparam int MSG_W   = 16;
    localparam int ID_W    = 16;
    localparam int LEN_W   = 11;
    localparam int FO_W    = 16;
    localparam int CSUM_W  = 16;
    localparam int IDX_W   = 6;
    localparam int ADDR_W  = 32;
    localparam int ACC_W   = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LEN_W-1:0]  HDR_BYTES     = 11'd20;
    localparam logic [LEN_W-1:0]  PAYLOAD_CAP   = 11'd1480;
    localparam logic [LEN_W-1:0]  PAYLOAD_MIN   = 11'd8;
    localparam logic [LEN_W-1:0]  PAYLOAD_MASK  = 11'h7F8;
    localparam logic [FO_W-1:0]   FLAG_DF       = 16'h4000;
    localparam logic [FO_W-1:0]   FLAG_MF       = 16'h2000;
    // version/IHL/TOS word plus TTL/protocol word
    localparam logic [ACC_W-1:0]  CSUM_CONST    = 20'h04500 + 20'h0FF01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAG_PAYLOAD = 2'd0,
        CFG_SRC_ADDR     = 2'd1,
        CFG_DST_ADDR     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]  pay;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } cfg_t;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_INIT,
        ALU_ADD,
        ALU_ADD_BASE,
        ALU_SAVE,
        ALU_FOLD
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [CSUM_W-1:0] operand;
    } alu_ctrl_t;

endpackage
`default_nettype wire

/* design/ifhg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg interfaces
// Request, fragment and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifhg_req_if;
    import ifhg_pkg::*;
    logic              valid;
    logic              ready;
    logic [MSG_W-1:0]  message_bytes;
    logic [ID_W-1:0]   datagram_id;

    modport source (output valid, message_bytes, datagram_id, input ready);
    modport sink   (input valid, message_bytes, datagram_id, output ready);
endinterface

interface ifhg_frag_if;
    import ifhg_pkg::*;
    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  fragment_length;
    logic [FO_W-1:0]   flags_offset;
    logic [CSUM_W-1:0] header_checksum;
    logic [IDX_W-1:0]  fragment_index;
    logic              last;
    logic              too_many;

    modport source (output valid, fragment_length, flags_offset, header_checksum,
                    fragment_index, last, too_many, input ready);
    modport sink   (input valid, fragment_length, flags_offset, header_checksum,
                    fragment_index, last, too_many, output ready);
endinterface

interface ifhg_cfg_if;
    import ifhg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/ifhg_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_cfg_regs
// Configuration registers; presents the clamped fragment payload size.
// ----------------------------------------------------------------------------
module ifhg_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    ifhg_cfg_if.sink       cfg,
    output ifhg_pkg::cfg_t cfg_out
);
    import ifhg_pkg::*;

    logic [LEN_W-1:0]  frag_payload_reg;
    logic [ADDR_W-1:0] src_addr_reg;
    logic [ADDR_W-1:0] dst_addr_reg;
    logic [LEN_W-1:0]  pay_masked;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_payload_reg <= PAYLOAD_CAP;
            src_addr_reg     <= '0;
            dst_addr_reg     <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_FRAG_PAYLOAD: frag_payload_reg <= cfg.data[LEN_W-1:0];
                CFG_SRC_ADDR:     src_addr_reg     <= cfg.data[ADDR_W-1:0];
                CFG_DST_ADDR:     dst_addr_reg     <= cfg.data[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    // round down to 8 bytes, clamp to 8..1480
    always_comb
    begin
        pay_masked = frag_payload_reg & PAYLOAD_MASK;
        if (pay_masked == '0)
            cfg_out.pay = PAYLOAD_MIN;
        else if (pay_masked > PAYLOAD_CAP)
            cfg_out.pay = PAYLOAD_CAP;
        else
            cfg_out.pay = pay_masked;
        cfg_out.src = src_addr_reg;
        cfg_out.dst = dst_addr_reg;
    end

endmodule
`default_nettype wire

/* design/ifhg_csum_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_csum_alu
// Shared checksum adder with accumulator and per-request base register.
// ----------------------------------------------------------------------------
module ifhg_csum_alu (
    input  logic                          clk,
    input  ifhg_pkg::alu_ctrl_t           ctrl,
    output logic [ifhg_pkg::CSUM_W-1:0]   checksum
);
    import ifhg_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] base_reg;
    logic [ACC_W-1:0] add_a;
    logic [ACC_W-1:0] add_b;
    logic [ACC_W-1:0] sum;

    always_comb
    begin
        add_a = acc_reg;
        add_b = ACC_W'(ctrl.operand);
        case (ctrl.op)
            ALU_ADD_BASE: add_a = base_reg;
            ALU_FOLD:
            begin
                add_a = ACC_W'(acc_reg[CSUM_W-1:0]);
                add_b = ACC_W'(acc_reg[ACC_W-1:CSUM_W]);
            end
            default: ;
        endcase
        sum = add_a + add_b;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            ALU_INIT:     acc_reg  <= CSUM_CONST;
            ALU_ADD:      acc_reg  <= sum;
            ALU_ADD_BASE: acc_reg  <= sum;
            ALU_FOLD:     acc_reg  <= sum;
            ALU_SAVE:     base_reg <= acc_reg;
            default:      ;
        endcase
    end

    assign checksum = ~acc_reg[CSUM_W-1:0];

endmodule
`default_nettype wire

/* design/ipv4_fragment_header_gen_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_fragment_header_gen_unit
// Splits one datagram request into IPv4 fragment header items.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one item per datagram (message_bytes, datagram_id). Ready only
//          while the sequencer is idle; a zero-length message yields nothing.
//   frag : one item per fragment, last set on the final one. A request that
//          needs more than MAX_FRAGMENTS fragments yields a single item with
//          too_many and last set and all other fields zero.
//   cfg  : register writes (0 frag_payload, 1 src_addr, 2 dst_addr), always
//          ready; write only while no request is in flight.
// Sequence:
//   A request first forms the address/id part of the checksum and checks
//   the fragment count, then runs each fragment through the shared
//   checksum adder (total, flags/offset, two folds, load); the next
//   request is accepted once the last item has moved into the output
//   register.
// Reset clears the sequencer and the output register and loads the register
// defaults. When frag stalls, the finished item holds in the output register
// and the sequencer holds at its load step.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_gen_unit #(
    parameter int MAX_FRAGMENTS = ifhg_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ifhg_req_if.sink     req,
    ifhg_frag_if.source  frag,
    ifhg_cfg_if.sink     cfg
);
    import ifhg_pkg::*;

    localparam int LIM_W = $clog2(MAX_FRAGMENTS * int'(PAYLOAD_CAP) + 1);
    localparam int CMP_W = (LIM_W > MSG_W) ? LIM_W : MSG_W;
    localparam logic [2:0] BASE_STEPS = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_CHECK,
        S_LEN,
        S_FO,
        S_FOLD1,
        S_FOLD2,
        S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [2:0]         step_reg;
    logic [MSG_W-1:0]   rem_reg;
    logic [MSG_W-1:0]   done_reg;
    logic [ID_W-1:0]    id_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   total_reg;
    logic [FO_W-1:0]    fo_reg;
    logic               final_reg;
    logic               too_many_reg;

    logic               out_valid_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [FO_W-1:0]    out_fo_reg;
    logic [CSUM_W-1:0]  out_csum_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_last_reg;
    logic               out_too_many_reg;

    cfg_t               cfg_q;
    alu_ctrl_t          alu_ctrl;
    logic [CSUM_W-1:0]  checksum;

    logic               req_accept;
    logic               emit_ok;
    logic               final_c;
    logic [LEN_W-1:0]   chunk_c;
    logic [LEN_W-1:0]   total_c;
    logic [FO_W-1:0]    fo_c;
    logic               too_many_c;

    ifhg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    ifhg_csum_alu u_alu (
        .clk      (clk),
        .ctrl     (alu_ctrl),
        .checksum (checksum)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign emit_ok    = !out_valid_reg || frag.ready;

    always_comb
    begin
        final_c = rem_reg <= MSG_W'(cfg_q.pay);
        chunk_c = final_c ? rem_reg[LEN_W-1:0] : cfg_q.pay;
        total_c = HDR_BYTES + chunk_c;
        if (idx_reg == '0 && final_c)
            fo_c = FLAG_DF;
        else
            fo_c = FO_W'(done_reg[MSG_W-1:3]) | (final_c ? '0 : FLAG_MF);
        too_many_c = CMP_W'(rem_reg) > CMP_W'(lim_reg);
    end

    // shared adder control
    always_comb
    begin
        alu_ctrl.op      = ALU_HOLD;
        alu_ctrl.operand = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                    alu_ctrl.op = ALU_INIT;
            end
            S_BASE:
            begin
                alu_ctrl.op = ALU_ADD;
                case (step_reg)
                    3'd0:    alu_ctrl.operand = cfg_q.src[31:16];
                    3'd1:    alu_ctrl.operand = cfg_q.src[15:0];
                    3'd2:    alu_ctrl.operand = cfg_q.dst[31:16];
                    3'd3:    alu_ctrl.operand = cfg_q.dst[15:0];
                    default: alu_ctrl.operand = id_reg;
                endcase
            end
            S_CHECK: alu_ctrl.op = ALU_SAVE;
            S_LEN:
            begin
                alu_ctrl.op      = ALU_ADD_BASE;
                alu_ctrl.operand = CSUM_W'(total_c);
            end
            S_FO:
            begin
                alu_ctrl.op      = ALU_ADD;
                alu_ctrl.operand = fo_reg;
            end
            S_FOLD1: alu_ctrl.op = ALU_FOLD;
            S_FOLD2: alu_ctrl.op = ALU_FOLD;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept && req.message_bytes != '0)
                    state_next = S_BASE;
            end
            S_BASE:
            begin
                if (step_reg == BASE_STEPS)
                    state_next = S_CHECK;
            end
            S_CHECK: state_next = too_many_c ? S_EMIT : S_LEN;
            S_LEN:   state_next = S_FO;
            S_FO:    state_next = S_FOLD1;
            S_FOLD1: state_next = S_FOLD2;
            S_FOLD2: state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_ok)
                    state_next = (too_many_reg || final_reg) ? S_IDLE : S_LEN;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            rem_reg          <= '0;
            done_reg         <= '0;
            id_reg           <= '0;
            lim_reg          <= '0;
            idx_reg          <= '0;
            total_reg        <= '0;
            fo_reg           <= '0;
            final_reg        <= 1'b0;
            too_many_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_len_reg      <= '0;
            out_fo_reg       <= '0;
            out_csum_reg     <= '0;
            out_idx_reg      <= '0;
            out_last_reg     <= 1'b0;
            out_too_many_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_EMIT && emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && frag.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        rem_reg      <= req.message_bytes;
                        id_reg       <= req.datagram_id;
                        lim_reg      <= LIM_W'(cfg_q.pay) * LIM_W'(MAX_FRAGMENTS);
                        done_reg     <= '0;
                        idx_reg      <= '0;
                        step_reg     <= '0;
                        too_many_reg <= 1'b0;
                    end
                end
                S_BASE:  step_reg     <= step_reg + 3'd1;
                S_CHECK: too_many_reg <= too_many_c;
                S_LEN:
                begin
                    total_reg <= total_c;
                    fo_reg    <= fo_c;
                    final_reg <= final_c;
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_too_many_reg <= too_many_reg;
                        out_last_reg     <= too_many_reg || final_reg;
                        if (too_many_reg)
                        begin
                            out_len_reg  <= '0;
                            out_fo_reg   <= '0;
                            out_csum_reg <= '0;
                            out_idx_reg  <= '0;
                        end
                        else
                        begin
                            out_len_reg  <= total_reg;
                            out_fo_reg   <= fo_reg;
                            out_csum_reg <= checksum;
                            out_idx_reg  <= idx_reg;
                        end
                        // advance to the next fragment
                        rem_reg  <= rem_reg - MSG_W'(cfg_q.pay);
                        done_reg <= done_reg + MSG_W'(cfg_q.pay);
                        idx_reg  <= idx_reg + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign frag.valid           = out_valid_reg;
    assign frag.fragment_length = out_len_reg;
    assign frag.flags_offset    = out_fo_reg;
    assign frag.header_checksum = out_csum_reg;
    assign frag.fragment_index  = out_idx_reg;
    assign frag.last            = out_last_reg;
    assign frag.too_many        = out_too_many_reg;

endmodule
`default_nettype wire

/* design/ifhg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_checker
// Port-level checks of the fragment header generator, bound to the top.
// ----------------------------------------------------------------------------
module ifhg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        frag_valid,
    input logic        frag_ready,
    input logic [10:0] frag_len,
    input logic [15:0] frag_fo,
    input logic [5:0]  frag_idx,
    input logic        frag_last,
    input logic        frag_too_many
);

    a_too_many_last: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && frag_too_many |-> frag_last)
        else $error("too_many item without last");

    a_too_many_zero: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && frag_too_many |-> frag_len == 11'd0 && frag_idx == 6'd0)
        else $error("too_many item with nonzero fields");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_too_many |-> frag_len >= 11'd21 && frag_len <= 11'd1500)
        else $error("fragment length out of range");

    a_mf_on_middle: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_last |-> frag_fo[13] && !frag_fo[14])
        else $error("non-final fragment without MF");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_ready |=> frag_valid && $stable(frag_fo))
        else $error("stalled item dropped or changed");

endmodule

bind ipv4_fragment_header_gen_unit ifhg_checker u_ifhg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .frag_valid    (frag.valid),
    .frag_ready    (frag.ready),
    .frag_len      (frag.fragment_length),
    .frag_fo       (frag.flags_offset),
    .frag_idx      (frag.fragment_index),
    .frag_last     (frag.last),
    .frag_too_many (frag.too_many)
);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4 fragment header generator. A queue-fed
// driver offers datagram requests, a monitor compares every fragment header
// item with a local predictor of lengths, flags/offset, checksum and index.
// Directed corner requests come first, then random phases with new register
// settings, random idle cycles on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import ifhg_pkg::*;

    localparam logic [15:0] WORD_VER_TOS   = 16'h4500;
    localparam logic [15:0] WORD_TTL_PROTO = 16'hFF01;
    localparam cfg_idx_t    CFG_SPARE      = cfg_idx_t'(2'd3);
    localparam int          RAND_PHASES     = 10;
    localparam int          ITEMS_PER_PHASE = 26;
    localparam int          SETTLE_CYCLES   = 20;
    localparam int          HOLD_AT         = 30;
    localparam int          LONG_HOLD       = 300;
    localparam int          WATCHDOG_LIMIT  = 2000;

    typedef struct packed {
        logic [LEN_W-1:0]  fragment_length;
        logic [FO_W-1:0]   flags_offset;
        logic [CSUM_W-1:0] header_checksum;
        logic [IDX_W-1:0]  fragment_index;
        logic              last;
        logic              too_many;
    } frag_hdr_t;

    typedef struct packed {
        logic [MSG_W-1:0] msg;
        logic [ID_W-1:0]  id;
    } dgram_req_t;

    logic clk;
    logic rst_n;

    ifhg_req_if  req_ch ();
    ifhg_frag_if frag_ch ();
    ifhg_cfg_if  cfg_ch ();

    ipv4_fragment_header_gen_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .frag  (frag_ch),
        .cfg   (cfg_ch)
    );

    dgram_req_t dgram_pending_q[$];
    frag_hdr_t  hdr_expect_q[$];

    logic [LEN_W-1:0]  cfg_pay_q;
    logic [ADDR_W-1:0] cfg_src_q;
    logic [ADDR_W-1:0] cfg_dst_q;

    int unsigned req_queued    = 0;
    int unsigned req_accepted  = 0;
    int unsigned hdrs_checked  = 0;
    int unsigned overflow_seen = 0;
    int unsigned reg_writes    = 0;
    int unsigned fail_count    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned req_gap       = 0;
    int unsigned frag_stall    = 0;
    int unsigned hold_cnt      = 0;
    bit          hold_used     = 1'b0;
    bit          req_idle_en   = 1'b0;
    bit          frag_idle_en  = 1'b0;
    logic        req_took      = 1'b0;
    logic        frag_took     = 1'b0;

    function automatic int unsigned eff_payload();
        int unsigned p;
        p = cfg_pay_q & PAYLOAD_MASK;
        if (p == 0)
            p = PAYLOAD_MIN;
        if (p > PAYLOAD_CAP)
            p = PAYLOAD_CAP;
        return p;
    endfunction

    function automatic logic [15:0] hdr_checksum(input int unsigned total,
                                                 input logic [15:0] id,
                                                 input logic [15:0] fo);
        logic [31:0] acc;
        acc = 32'(WORD_VER_TOS) + 32'(WORD_TTL_PROTO) + total + 32'(id) + 32'(fo)
            + 32'(cfg_src_q[31:16]) + 32'(cfg_src_q[15:0])
            + 32'(cfg_dst_q[31:16]) + 32'(cfg_dst_q[15:0]);
        acc = 32'(acc[31:16]) + 32'(acc[15:0]);
        acc = acc + 32'(acc[31:16]);
        return ~acc[15:0];
    endfunction

    function automatic void predict_headers(input logic [MSG_W-1:0] msg,
                                            input logic [ID_W-1:0] id);
        int unsigned pay;
        int unsigned count;
        int unsigned done;
        int unsigned chunk;
        int unsigned total;
        int unsigned k;
        logic [15:0] fo;
        frag_hdr_t   h;
        pay = eff_payload();
        if (msg == 0)
            return;
        count = (32'(msg) + pay - 1) / pay;
        if (count > MAX_FRAGMENTS_DEF)
        begin
            h          = '0;
            h.last     = 1'b1;
            h.too_many = 1'b1;
            hdr_expect_q.push_back(h);
            return;
        end
        for (k = 0; k < count; k++)
        begin
            done  = k * pay;
            chunk = (32'(msg) - done < pay) ? 32'(msg) - done : pay;
            total = 32'(HDR_BYTES) + chunk;
            fo    = 16'(done >> 3) & 16'h1FFF;
            if (count == 1)
                fo = FLAG_DF;
            else if (k + 1 != count)
                fo = fo | FLAG_MF;
            h.fragment_length = LEN_W'(total);
            h.flags_offset    = fo;
            h.header_checksum = hdr_checksum(total, id, fo);
            h.fragment_index  = IDX_W'(k);
            h.last            = (k + 1 == count);
            h.too_many        = 1'b0;
            hdr_expect_q.push_back(h);
        end
    endfunction

    function automatic string hdr_str(input frag_hdr_t h);
        return $sformatf("len=%0d fo=%h csum=%h idx=%0d last=%b too_many=%b",
                         h.fragment_length, h.flags_offset, h.header_checksum,
                         h.fragment_index, h.last, h.too_many);
    endfunction

    task automatic queue_req(input logic [MSG_W-1:0] msg, input logic [ID_W-1:0] id);
        dgram_req_t r;
        r.msg = msg;
        r.id  = id;
        dgram_pending_q.push_back(r);
        req_queued++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_FRAG_PAYLOAD: cfg_pay_q = val[LEN_W-1:0];
            CFG_SRC_ADDR:     cfg_src_q = val;
            CFG_DST_ADDR:     cfg_dst_q = val;
            default:          ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_accepted != req_queued || hdr_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin : req_driver
        dgram_req_t r;
        if (rst_n && (!req_ch.valid || req_took))
        begin
            if (req_gap != 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (dgram_pending_q.size() != 0)
            begin
                r = dgram_pending_q.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.message_bytes <= r.msg;
                req_ch.datagram_id   <= r.id;
                req_gap = req_idle_en ? $urandom_range(0, 14) : 0;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : req_tracker
        req_took <= req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_headers(req_ch.message_bytes, req_ch.datagram_id);
            req_accepted <= req_accepted + 1;
        end
    end

    // hold off the output once for a long stretch
    always @(negedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (!hold_used && req_accepted >= HOLD_AT)
            begin
                hold_used <= 1'b1;
                hold_cnt  <= LONG_HOLD;
            end
            else if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
            end
        end
    end

    always @(negedge clk)
    begin : frag_pacer
        if (rst_n)
        begin
            if (frag_took)
                frag_stall = frag_idle_en ? $urandom_range(0, 14) : 0;
            if (frag_stall != 0)
            begin
                frag_stall--;
                frag_ch.ready <= 1'b0;
            end
            else
            begin
                frag_ch.ready <= (hold_cnt == 0);
            end
        end
    end

    always @(posedge clk)
    begin : frag_monitor
        frag_hdr_t got;
        frag_hdr_t want;
        frag_took <= frag_ch.valid && frag_ch.ready;
        if (rst_n && frag_ch.valid && frag_ch.ready)
        begin
            got = {frag_ch.fragment_length, frag_ch.flags_offset, frag_ch.header_checksum,
                   frag_ch.fragment_index, frag_ch.last, frag_ch.too_many};
            if (hdr_expect_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected item, expected none, got %s", $time, hdr_str(got));
            end
            else
            begin
                want = hdr_expect_q.pop_front();
                hdrs_checked++;
                if (got.too_many)
                    overflow_seen++;
                if (got !== want)
                begin
                    fail_count++;
                    $display("%0t: mismatch, expected %s", $time, hdr_str(want));
                    $display("%0t:           actual   %s", $time, hdr_str(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (frag_ch.valid && frag_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress, %0d headers outstanding", $time,
                         hdr_expect_q.size());
                $display("[ipv4_fragment_header_gen_unit] ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned        ph;
        int unsigned        msg;
        int unsigned        pay;
        logic [CFG_DATA_W-1:0] pay_data;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.message_bytes = '0;
        req_ch.datagram_id   = '0;
        frag_ch.ready        = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_FRAG_PAYLOAD;
        cfg_ch.data          = '0;
        cfg_pay_q            = PAYLOAD_CAP;
        cfg_src_q            = '0;
        cfg_dst_q            = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: single fragment, split, longest messages, empty
        req_idle_en  = 1'b1;
        frag_idle_en = 1'b1;
        queue_req(16'd1, 16'h0000);
        queue_req(16'd1480, 16'hFFFF);
        queue_req(16'd1481, 16'h1234);
        queue_req(16'd65515, 16'hA5A5);
        queue_req(16'd65535, 16'h5A5A);
        queue_req(16'd0, 16'h0007);
        wait_idle();

        // smallest payload: full fragment count, one over, carries in the sum
        write_reg(CFG_FRAG_PAYLOAD, 32'(PAYLOAD_MIN));
        write_reg(CFG_SRC_ADDR, 32'hFFFF_FFFF);
        write_reg(CFG_DST_ADDR, 32'hFFFF_FFFF);
        queue_req(16'd512, 16'hFFFF);
        queue_req(16'd513, 16'h0001);
        queue_req(16'd8, 16'h8000);
        queue_req(16'd9, 16'h00FF);
        queue_req(16'd65535, 16'hFFFF);
        wait_idle();

        // payload values that round, floor or clamp
        write_reg(CFG_FRAG_PAYLOAD, 32'd0);
        write_reg(CFG_SRC_ADDR, 32'h0A00_0001);
        write_reg(CFG_DST_ADDR, 32'hC0A8_0001);
        write_reg(CFG_SPARE, 32'hDEAD_BEEF);
        queue_req(16'd20, 16'h4321);
        wait_idle();
        write_reg(CFG_FRAG_PAYLOAD, 32'd7);
        queue_req(16'd17, 16'h1111);
        wait_idle();
        write_reg(CFG_FRAG_PAYLOAD, 32'hFFFF_FFFF);
        queue_req(16'd3000, 16'h2222);
        wait_idle();
        write_reg(CFG_FRAG_PAYLOAD, 32'd1483);
        queue_req(16'd2961, 16'h3333);
        wait_idle();
        write_reg(CFG_FRAG_PAYLOAD, 32'd100);
        queue_req(16'd200, 16'h4444);
        wait_idle();
        write_reg(CFG_FRAG_PAYLOAD, 32'd1488);
        queue_req(16'd1489, 16'h5555);
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 5)
                0:       pay_data = 32'(PAYLOAD_MIN);
                1:       pay_data = 32'(PAYLOAD_CAP);
                2:       pay_data = $urandom_range(1, 185) * 8;
                3:       pay_data = $urandom;
                default: pay_data = $urandom_range(1, 16) * 8;
            endcase
            write_reg(CFG_FRAG_PAYLOAD, pay_data);
            write_reg(CFG_SRC_ADDR, $urandom);
            write_reg(CFG_DST_ADDR, $urandom);
            req_idle_en  = ph[0];
            frag_idle_en = ph[1];
            pay = eff_payload();
            repeat (ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0:       msg = $urandom_range(0, 65535);
                    1:       msg = 0;
                    2:       msg = pay * MAX_FRAGMENTS_DEF + $urandom_range(0, 1);
                    3:       msg = pay * $urandom_range(1, 8);
                    default: msg = $urandom_range(1, pay * $urandom_range(1, 6));
                endcase
                if (msg > 65535)
                    msg = 65535;
                queue_req(16'(msg), 16'($urandom));
            end
            wait_idle();
        end

        $display("Checked %0d fragment headers from %0d requests, %0d over the fragment limit,",
                 hdrs_checked, req_accepted, overflow_seen);
        $display("after %0d register writes, with and without idle cycles on both channels.",
                 reg_writes);
        if (fail_count == 0)
            $display("[ipv4_fragment_header_gen_unit] OK");
        else
            $display("[ipv4_fragment_header_gen_unit] ERROR");
        $finish;
    end

endmodule
